/* rtl/core/sst_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted score table package
// Shared sizes, operation and status codes, and the result record passed
// from the sequencer to the output stage.
// ----------------------------------------------------------------------------
package sst_pkg;

    // Table geometry.
    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    // Field widths.
    localparam int OP_W     = 2;
    localparam int KEY_W    = 8;
    localparam int SCORE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int RANK_W   = 6;

    // Stream data widths, padded to whole bytes.
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 48;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_REG  = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD  = 2'd1;
    localparam logic [OP_W-1:0] OP_DUMP = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    // Shared adder modes.
    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_mode_t;

    // One result item.
    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [RANK_W-1:0]         rank;
        logic [KEY_W-1:0]          key;
        logic signed [SCORE_W-1:0] score;
        logic                      last;
    } res_t;

endpackage

/* rtl/core/sorted_score_table_update.sv */
// A register item's result passes through the sequencer result register and
// the output register. An add walks the table to find the key, then walks it
// again to place the updated entry; an unknown key ends after the find walk.
// A dump gives one item per cycle while the output stage accepts; n entries, n items.
// One input item is handled at a time; the next is taken after the last result.
// Reset (aresetn low, synchronous) empties the table; no clearing pass is run.
// ----------------------------------------------------------------------------
// Sorted score table update
// Keeps keyed scores in rank order; registers keys, applies saturating score
// updates with reordering, and dumps the table over a stream interface.
// ----------------------------------------------------------------------------
module sorted_score_table_update (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [1:0] op, [9:2] key, [41:10] delta, [47:42] zero
    input  logic [sst_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [1:0] status, [7:2] rank, [15:8] entry_key, [47:16] entry_score
    output logic [sst_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                             m_tlast
);
    import sst_pkg::*;

    logic  res_valid;
    logic  res_ready;
    res_t  res;
    logic  out_valid_reg, out_valid_next;
    res_t  out_reg, out_next;

    sst_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tdata[OP_W-1:0]),
        .in_key    (s_tdata[OP_W+KEY_W-1:OP_W]),
        .in_delta  (s_tdata[OP_W+KEY_W+SCORE_W-1:OP_W+KEY_W]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: free when empty or being drained this cycle.
    assign res_ready = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid && res_ready) begin
            out_valid_next = 1'b1;
            out_next       = res;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.score, out_reg.key, out_reg.rank, out_reg.status};
    assign m_tlast  = out_reg.last;

endmodule

/* rtl/core/sst_alu.sv */
// ----------------------------------------------------------------------------
// Sorted score table shared adder
// One 33-bit adder used either for the saturating score update or for the
// signed less-than compare during placement.
// ----------------------------------------------------------------------------
module sst_alu (
    input  sst_pkg::alu_mode_t                   mode,
    input  logic signed [sst_pkg::SCORE_W-1:0]   op_a,
    input  logic signed [sst_pkg::SCORE_W-1:0]   op_b,
    output logic signed [sst_pkg::SCORE_W-1:0]   sat_sum,
    output logic                                 less
);
    import sst_pkg::*;

    logic [SCORE_W:0] a_ext;
    logic [SCORE_W:0] b_ext;
    logic [SCORE_W:0] wide;

    // Sign-extend both operands by one bit so the result never wraps.
    assign a_ext = {op_a[SCORE_W-1], op_a};
    assign b_ext = {op_b[SCORE_W-1], op_b};
    assign wide  = (mode == ALU_ADD) ? (a_ext + b_ext) : (a_ext - b_ext);

    // The true sign of the difference gives a < b.
    assign less = wide[SCORE_W];

    // Clamp the sum when the two top bits disagree.
    always_comb begin
        if (wide[SCORE_W] != wide[SCORE_W-1]) begin
            sat_sum = wide[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}}
                                    : {1'b0, {(SCORE_W-1){1'b1}}};
        end else begin
            sat_sum = wide[SCORE_W-1:0];
        end
    end

endmodule

/* rtl/core/sst_ctrl.sv */
// ----------------------------------------------------------------------------
// Sorted score table sequencer
// Holds the key and score memories and walks them one entry per cycle to find
// a key, reposition an updated entry, or read the table out (dumps wait on output).
// ----------------------------------------------------------------------------
module sst_ctrl (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [sst_pkg::OP_W-1:0]             in_op,
    input  logic [sst_pkg::KEY_W-1:0]            in_key,
    input  logic signed [sst_pkg::SCORE_W-1:0]   in_delta,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output sst_pkg::res_t                        res
);
    import sst_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FIND  = 7'b0000010,
        S_PLACE = 7'b0000100,
        S_DOWN  = 7'b0001000,
        S_UP    = 7'b0010000,
        S_DUMP  = 7'b0100000,
        S_RESP  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [KEY_W-1:0]          key_reg, key_next;
    logic signed [SCORE_W-1:0] delta_reg, delta_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [IDX_W-1:0]          j_reg, j_next;
    logic [IDX_W-1:0]          pos_reg, pos_next;
    logic signed [SCORE_W-1:0] s_reg, s_next;
    logic [KEY_W-1:0]          carry_key_reg, carry_key_next;
    logic signed [SCORE_W-1:0] carry_score_reg, carry_score_next;
    res_t                      res_reg, res_next;

    // Table memory with one write and one registered read port.
    logic [KEY_W-1:0]          key_mem [MAX_ENTRIES];
    logic signed [SCORE_W-1:0] score_mem [MAX_ENTRIES];
    logic                      wr_en;
    logic [IDX_W-1:0]          wr_addr;
    logic [KEY_W-1:0]          wr_key;
    logic signed [SCORE_W-1:0] wr_score;
    logic [IDX_W-1:0]          rd_addr;
    logic [KEY_W-1:0]          rd_key;
    logic signed [SCORE_W-1:0] rd_score;

    // Shared adder hookup.
    alu_mode_t                 alu_mode;
    logic signed [SCORE_W-1:0] alu_b;
    logic signed [SCORE_W-1:0] alu_sum;
    logic                      alu_less;

    logic [IDX_W-1:0] last_idx;
    res_t             dump_res;

    assign last_idx = IDX_W'(cnt_reg - CNT_W'(1));

    sst_alu u_alu (
        .mode    (alu_mode),
        .op_a    (rd_score),
        .op_b    (alu_b),
        .sat_sum (alu_sum),
        .less    (alu_less)
    );

    // Memory write and registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_addr]   <= wr_key;
            score_mem[wr_addr] <= wr_score;
        end
        rd_key   <= key_mem[rd_addr];
        rd_score <= score_mem[rd_addr];
    end

    // Dump results come straight from the read port.
    always_comb begin
        dump_res.status = ST_OK;
        dump_res.rank   = RANK_W'(j_reg);
        dump_res.key    = rd_key;
        dump_res.score  = rd_score;
        dump_res.last   = (j_reg == last_idx);
    end

    assign res = (state_reg == S_DUMP) ? dump_res : res_reg;

    // Sequencer.
    always_comb begin
        state_next       = state_reg;
        key_next         = key_reg;
        delta_next       = delta_reg;
        cnt_next         = cnt_reg;
        j_next           = j_reg;
        pos_next         = pos_reg;
        s_next           = s_reg;
        carry_key_next   = carry_key_reg;
        carry_score_next = carry_score_reg;
        res_next         = res_reg;
        in_ready         = 1'b0;
        res_valid        = 1'b0;
        wr_en            = 1'b0;
        wr_addr          = j_reg;
        wr_key           = key_reg;
        wr_score         = s_reg;
        rd_addr          = j_reg + IDX_W'(1);
        alu_mode         = ALU_SUB;
        alu_b            = s_reg;

        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                rd_addr  = '0;
                if (in_valid) begin
                    key_next   = in_key;
                    delta_next = in_delta;
                    j_next     = '0;
                    case (in_op)
                        OP_REG: begin
                            if (cnt_reg == CNT_W'(MAX_ENTRIES)) begin
                                res_next = '{ST_FULL, '0, in_key, '0, 1'b1};
                            end else begin
                                wr_en    = 1'b1;
                                wr_addr  = cnt_reg[IDX_W-1:0];
                                wr_key   = in_key;
                                wr_score = '0;
                                cnt_next = cnt_reg + CNT_W'(1);
                                res_next = '{ST_OK, RANK_W'(cnt_reg), in_key, '0, 1'b1};
                            end
                            state_next = S_RESP;
                        end
                        OP_ADD: begin
                            if (cnt_reg == '0) begin
                                res_next   = '{ST_NOT_FOUND, '0, in_key, '0, 1'b1};
                                state_next = S_RESP;
                            end else begin
                                state_next = S_FIND;
                            end
                        end
                        OP_DUMP: begin
                            if (cnt_reg == '0) begin
                                res_next   = '{ST_EMPTY, '0, '0, '0, 1'b1};
                                state_next = S_RESP;
                            end else begin
                                state_next = S_DUMP;
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Scan for the first entry with the key; update its score on a hit.
            S_FIND: begin
                alu_mode = ALU_ADD;
                alu_b    = delta_reg;
                if (rd_key == key_reg) begin
                    pos_next   = j_reg;
                    s_next     = alu_sum;
                    j_next     = '0;
                    rd_addr    = '0;
                    state_next = S_PLACE;
                end else if (j_reg == last_idx) begin
                    res_next   = '{ST_NOT_FOUND, '0, key_reg, '0, 1'b1};
                    state_next = S_RESP;
                end else begin
                    j_next = j_reg + IDX_W'(1);
                end
            end

            // Entries ahead of the old position: look for a lower score.
            S_PLACE: begin
                if (j_reg == pos_reg) begin
                    if (pos_reg == last_idx) begin
                        wr_en      = 1'b1;
                        res_next   = '{ST_OK, RANK_W'(j_reg), key_reg, s_reg, 1'b1};
                        state_next = S_RESP;
                    end else begin
                        state_next = S_UP;
                    end
                end else if (alu_less) begin
                    wr_en            = 1'b1;
                    carry_key_next   = rd_key;
                    carry_score_next = rd_score;
                    res_next         = '{ST_OK, RANK_W'(j_reg), key_reg, s_reg, 1'b1};
                    j_next           = j_reg + IDX_W'(1);
                    state_next       = S_DOWN;
                end else begin
                    j_next = j_reg + IDX_W'(1);
                end
            end

            // Entry moved toward the head: ripple the displaced entries back.
            S_DOWN: begin
                wr_en    = 1'b1;
                wr_key   = carry_key_reg;
                wr_score = carry_score_reg;
                if (j_reg == pos_reg) begin
                    state_next = S_RESP;
                end else begin
                    carry_key_next   = rd_key;
                    carry_score_next = rd_score;
                    j_next           = j_reg + IDX_W'(1);
                end
            end

            // Entry moved toward the tail: pull later entries forward.
            S_UP: begin
                if (j_reg == last_idx || alu_less) begin
                    wr_en      = 1'b1;
                    res_next   = '{ST_OK, RANK_W'(j_reg), key_reg, s_reg, 1'b1};
                    state_next = S_RESP;
                end else begin
                    wr_en    = 1'b1;
                    wr_key   = rd_key;
                    wr_score = rd_score;
                    j_next   = j_reg + IDX_W'(1);
                    rd_addr  = j_reg + IDX_W'(2);
                end
            end

            // Read the table out one entry per accepted item.
            S_DUMP: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    if (j_reg == last_idx) begin
                        state_next = S_IDLE;
                    end else begin
                        j_next = j_reg + IDX_W'(1);
                    end
                end else begin
                    rd_addr = j_reg;
                end
            end

            S_RESP: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Working registers.
    always_ff @(posedge aclk) begin
        key_reg         <= key_next;
        delta_reg       <= delta_next;
        j_reg           <= j_next;
        pos_reg         <= pos_next;
        s_reg           <= s_next;
        carry_key_reg   <= carry_key_next;
        carry_score_reg <= carry_score_next;
        res_reg         <= res_next;
    end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// Sorted score table update testbench
// Drives register, add, dump and unused-code items into the table over the
// input stream. A local copy of the table in the scoreboard predicts every
// result item, and each result on the output stream is checked field by
// field. The run covers several phases of sender and receiver idling and one
// long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sst_pkg::*;

    // Unused operation code, ignored by the block.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Receiver hold-off length, in cycles.
    localparam int HOLD_CYCLES = 400;

    // Random items per idling phase.
    localparam int PHASE_ITEMS = 41;

    // Scoreboard: keeps its own rank-ordered table and the results it implies.
    class rank_table_model;
        logic [KEY_W-1:0]          keys   [MAX_ENTRIES];
        logic signed [SCORE_W-1:0] scores [MAX_ENTRIES];
        int                        count;
        res_t                      expected_results [$];
        int                        errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function void push_result(logic [STATUS_W-1:0] status, int rank,
                                  logic [KEY_W-1:0] key, logic [SCORE_W-1:0] score,
                                  logic last);
            res_t r;
            r.status = status;
            r.rank   = RANK_W'(rank);
            r.key    = key;
            r.score  = score;
            r.last   = last;
            expected_results.push_back(r);
        endfunction

        // Update the table for one accepted item and queue its results.
        function void note_item(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                logic signed [SCORE_W-1:0] delta);
            int                        pos;
            int                        dst;
            longint                    sum;
            logic signed [SCORE_W-1:0] new_score;
            case (op)
                OP_REG: begin
                    if (count >= MAX_ENTRIES) begin
                        push_result(ST_FULL, 0, key, '0, 1'b1);
                    end else begin
                        keys[count]   = key;
                        scores[count] = '0;
                        push_result(ST_OK, count, key, '0, 1'b1);
                        count++;
                    end
                end
                OP_ADD: begin
                    pos = 0;
                    while (pos < count && keys[pos] != key) pos++;
                    if (pos >= count) begin
                        push_result(ST_NOT_FOUND, 0, key, '0, 1'b1);
                    end else begin
                        // Saturating sum of the old score and the delta.
                        sum = longint'(scores[pos]) + longint'(delta);
                        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
                        if (sum < -64'sd2147483648) sum = -64'sd2147483648;
                        new_score = SCORE_W'(sum);
                        // Take the entry out, then close the hole.
                        for (int i = pos; i + 1 < count; i++) begin
                            keys[i]   = keys[i + 1];
                            scores[i] = scores[i + 1];
                        end
                        // The entry goes just ahead of the first strictly lower score.
                        dst = 0;
                        while (dst + 1 < count && !(scores[dst] < new_score)) dst++;
                        for (int i = count - 1; i > dst; i--) begin
                            keys[i]   = keys[i - 1];
                            scores[i] = scores[i - 1];
                        end
                        keys[dst]   = key;
                        scores[dst] = new_score;
                        push_result(ST_OK, dst, key, new_score, 1'b1);
                    end
                end
                OP_DUMP: begin
                    if (count == 0) begin
                        push_result(ST_EMPTY, 0, '0, '0, 1'b1);
                    end else begin
                        for (int i = 0; i < count; i++)
                            push_result(ST_OK, i, keys[i], scores[i], i + 1 == count);
                    end
                end
                default: begin
                    // The unused code gives nothing and leaves the table alone.
                end
            endcase
        endfunction

        function void compare_field(string name, logic [SCORE_W-1:0] want,
                                    logic [SCORE_W-1:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare one result item with the oldest expectation.
        function void check_result(logic [M_DATA_W-1:0] data, logic last);
            res_t want;
            res_t got;
            got.status = data[1:0];
            got.rank   = data[7:2];
            got.key    = data[15:8];
            got.score  = data[47:16];
            got.last   = last;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %h last %b",
                         $time, data, last);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("status", SCORE_W'(want.status), SCORE_W'(got.status));
            compare_field("rank", SCORE_W'(want.rank), SCORE_W'(got.rank));
            compare_field("entry_key", SCORE_W'(want.key), SCORE_W'(got.key));
            compare_field("entry_score", want.score, got.score);
            compare_field("last", SCORE_W'(want.last), SCORE_W'(got.last));
        endfunction
    endclass

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;

    int idle_pct     = 0;
    int stall_pct    = 0;
    bit hold_request = 1'b0;
    bit hold_taken   = 1'b0;
    int hold_left    = 0;

    rank_table_model model = new();

    sorted_score_table_update uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 12 ns clock.
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Receiver: random stalls, plus one long hold-off when requested.
    always @(negedge aclk) begin
        if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready = 1'b0;
        end else begin
            m_tready = ($urandom_range(99) >= stall_pct);
        end
    end

    // Check every result item taken by the receiver.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) model.check_result(m_tdata, m_tlast);
    end

    // Offer one item, with random idle cycles first, and note it once accepted.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                             input logic [SCORE_W-1:0] delta);
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {6'b0, delta, key, op};
        do @(posedge aclk); while (!s_tready);
        model.note_item(op, key, delta);
    endtask

    // Score increments: small steps most often, with ties, extremes and full-range values.
    function automatic logic [SCORE_W-1:0] pick_delta();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40) return SCORE_W'($signed($urandom_range(4096)) - 2048);
        if (sel < 55) return '0;
        if (sel < 62) return 32'h7fff_ffff;
        if (sel < 69) return 32'h8000_0000;
        return $urandom();
    endfunction

    // One random item; returns the op so that ignored items are not counted.
    task automatic send_random_item(output logic [OP_W-1:0] op);
        int                 sel;
        logic [KEY_W-1:0]   key;
        logic [SCORE_W-1:0] delta;
        sel   = $urandom_range(99);
        key   = $urandom_range(255);
        delta = $urandom();
        if (sel < 3) begin
            op = OP_UNUSED;
        end else if (sel < 15) begin
            op = OP_DUMP;
        end else if (sel < ((model.count < MAX_ENTRIES) ? 45 : 23)) begin
            op = OP_REG;
            // Reuse a known key now and then to build duplicates.
            if (model.count > 0 && $urandom_range(99) < 25)
                key = model.keys[$urandom_range(model.count - 1)];
        end else begin
            op    = OP_ADD;
            delta = pick_delta();
            if (model.count > 0 && $urandom_range(99) < 85)
                key = model.keys[$urandom_range(model.count - 1)];
        end
        send_item(op, key, delta);
    endtask

    // Main sequence.
    initial begin
        logic [OP_W-1:0] op;
        int              sent;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // Directed items, no idling.
        send_item(OP_DUMP, 8'h00, '0);           // dump of the empty table
        send_item(OP_ADD, 8'h3c, 32'h100);       // add on the empty table
        send_item(OP_UNUSED, 8'hff, 32'hffff_ffff);
        send_item(OP_REG, 8'hff, '0);
        send_item(OP_REG, 8'h00, '0);
        send_item(OP_REG, 8'hff, '0);            // duplicate key
        send_item(OP_REG, 8'ha5, 32'hffff_ffff);
        send_item(OP_ADD, 8'hff, 32'h7fff_ffff); // first duplicate only
        send_item(OP_ADD, 8'hff, 32'h7fff_ffff); // saturates high
        send_item(OP_ADD, 8'h00, 32'h8000_0000);
        send_item(OP_ADD, 8'h00, 32'h8000_0000); // saturates low
        send_item(OP_ADD, 8'hff, '0);            // tie with the head score
        send_item(OP_ADD, 8'ha5, 32'hffff_ff00);
        send_item(OP_ADD, 8'h5a, 32'h0000_0100); // unknown key
        send_item(OP_ADD, 8'hff, 32'h8000_0000); // drops from the head
        send_item(OP_DUMP, 8'h00, '0);

        // Random items over the idling phases.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 68; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 68; end
                default: begin idle_pct = 27; stall_pct = 27; end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if (phase == 0 && sent == 10) hold_request = 1'b1;
                send_random_item(op);
                if (op != OP_UNUSED) sent++;
            end
        end
        @(negedge aclk);
        s_tvalid = 1'b0;

        // Drain, then allow for any late or extra result.
        while (model.expected_results.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (model.errors == 0 && model.expected_results.size() == 0) begin
            $display("tb_top passed");
        end else begin
            if (model.expected_results.size() != 0)
                $display("%0t: %0d expected results never arrived", $time,
                         model.expected_results.size());
            $display("tb_top failed");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #10ms;
        $display("tb_top failed");
        $finish;
    end

endmodule
